>>> src/bcss_pkg.sv
package bcss_pkg;

   localparam int TIMER_BITS  = 24;
   localparam int TIMEOUT_W   = 24;
   localparam int CMP_W       = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
   localparam int TEMP_W      = 8;
   localparam int LEVEL_W     = 8;
   localparam int NEAR_W      = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [TIMEOUT_W-1:0]     FULL_TIMEOUT_RST = TIMEOUT_W'(144000);
   localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST     = TEMP_W'(0);
   localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST     = TEMP_W'(60);
   localparam logic [NEAR_W-1:0]        NEAR_FULL_RST    = NEAR_W'(95);

   // display correction breakpoints
   localparam logic [LEVEL_W-1:0] DISP_MAX       = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0] DISP_FULL_FROM = LEVEL_W'(96);
   localparam logic [LEVEL_W-1:0] DISP_BUMP_FROM = LEVEL_W'(86);
   localparam logic [LEVEL_W-1:0] DISP_BUMP      = LEVEL_W'(5);

   typedef enum logic [2:0] {
      CS_UNKNOWN      = 3'd0,
      CS_NOT_CHARGING = 3'd1,
      CS_CHARGING     = 3'd2,
      CS_NEARLY_DONE  = 3'd3,
      CS_FULL         = 3'd4
   } chg_state_type;

   typedef enum logic [1:0] {
      CHG_IDLE      = 2'd0,
      CHG_PRECHARGE = 2'd1,
      CHG_FAST      = 2'd2,
      CHG_DONE      = 2'd3
   } charger_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FULL_TIMEOUT = 2'd0,
      REG_MIN_TEMP     = 2'd1,
      REG_MAX_TEMP     = 2'd2,
      REG_NEAR_FULL    = 2'd3
   } csr_reg_type;

   // level * 100 / 95 = level * 20 / 19; 1/19 taken as 3450 / 2^16,
   // exact for the levels below the bump range
   function automatic logic [LEVEL_W-1:0] display_of(input logic [LEVEL_W-1:0] lvl);
      logic [12:0] scaled;
      logic [24:0] prod;
      scaled = 13'(lvl) * 13'd20;
      prod   = 25'(scaled) * 25'd3450;
      if (lvl > DISP_MAX) begin
         return lvl;
      end else if (lvl >= DISP_FULL_FROM) begin
         return DISP_MAX;
      end else if (lvl >= DISP_BUMP_FROM) begin
         return lvl + DISP_BUMP;
      end else begin
         return prod[23:16];
      end
   endfunction

endpackage

>>> src/bcss_if.sv
interface bcss_req_if;
   logic                      valid;
   logic                      ready;
   logic                      power_c_present;
   logic                      power_p_present;
   logic [7:0]                charge_level;
   logic signed [7:0]         battery_temp;
   logic                      gauge_healthy;
   logic                      status_valid;
   logic [1:0]                charger_status;

   modport source (
      output valid, power_c_present, power_p_present, charge_level, battery_temp,
             gauge_healthy, status_valid, charger_status,
      input  ready
   );
   modport sink (
      input  valid, power_c_present, power_p_present, charge_level, battery_temp,
             gauge_healthy, status_valid, charger_status,
      output ready
   );
endinterface

interface bcss_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] chg_state;
   logic       state_changed;
   logic [7:0] display_level;
   logic       charge_terminated;

   modport source (
      output valid, chg_state, state_changed, display_level, charge_terminated,
      input  ready
   );
   modport sink (
      input  valid, chg_state, state_changed, display_level, charge_terminated,
      output ready
   );
endinterface

interface bcss_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/battery_charge_state_supervisor.sv
// Charge state supervisor: takes one tick request per clock unless stalled and
// returns one result for each accepted request (the request sits in the input
// register, its result is loaded into the result register when it advances).
// Throughput is one request per cycle, limited only by the result register
// draining: a request is taken whenever the input register is empty or moves
// on to the result register in the same cycle. The charge-full timer counts
// accepted ticks, not clocks. Configuration writes are taken every cycle and
// should only be issued while no request is in flight.
module battery_charge_state_supervisor (
   input logic        clock,
   input logic        reset,
   bcss_req_if.sink   req_chan,
   bcss_rsp_if.source rsp_chan,
   bcss_csr_if.sink   csr_chan
);
   import bcss_pkg::*;

   // configuration
   logic [TIMEOUT_W-1:0]     full_timeout_ff;
   logic signed [TEMP_W-1:0] min_temp_ff;
   logic signed [TEMP_W-1:0] max_temp_ff;
   logic [NEAR_W-1:0]        near_full_ff;

   // input register
   logic                     stage_valid_ff;
   logic                     stage_pc_ff;
   logic                     stage_pp_ff;
   logic [LEVEL_W-1:0]       stage_level_ff;
   logic signed [TEMP_W-1:0] stage_temp_ff;
   logic                     stage_healthy_ff;
   logic                     stage_sv_ff;
   logic [1:0]               stage_status_ff;

   // supervisor state
   logic                     terminated_ff, terminated_in;
   chg_state_type            last_state_ff, last_state_in;
   logic                     armed_ff, armed_in;
   logic [TIMER_BITS-1:0]    count_ff, count_in;
   logic                     latched_ff, latched_in;

   // result register
   logic                     rsp_valid_ff;
   chg_state_type            rsp_state_ff;
   logic                     rsp_changed_ff;
   logic [LEVEL_W-1:0]       rsp_display_ff;
   logic                     rsp_term_ff;

   logic                     advance;
   logic                     req_fire;
   logic                     term_status;
   logic [TIMER_BITS-1:0]    count_adv;
   logic                     latched_adv;
   logic                     powered;
   logic                     run;
   chg_state_type            state_now;

   assign advance  = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_timeout_ff <= FULL_TIMEOUT_RST;
         min_temp_ff     <= MIN_TEMP_RST;
         max_temp_ff     <= MAX_TEMP_RST;
         near_full_ff    <= NEAR_FULL_RST;
      end else if (csr_chan.valid) begin
         case (csr_reg_type'(csr_chan.index))
            REG_FULL_TIMEOUT: full_timeout_ff <= csr_chan.data[TIMEOUT_W-1:0];
            REG_MIN_TEMP:     min_temp_ff     <= csr_chan.data[TEMP_W-1:0];
            REG_MAX_TEMP:     max_temp_ff     <= csr_chan.data[TEMP_W-1:0];
            REG_NEAR_FULL:    near_full_ff    <= csr_chan.data[NEAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_pc_ff      <= req_chan.power_c_present;
         stage_pp_ff      <= req_chan.power_p_present;
         stage_level_ff   <= req_chan.charge_level;
         stage_temp_ff    <= req_chan.battery_temp;
         stage_healthy_ff <= req_chan.gauge_healthy;
         stage_sv_ff      <= req_chan.status_valid;
         stage_status_ff  <= req_chan.charger_status;
      end
   end

   always_comb begin
      term_status = stage_sv_ff ? (charger_status_type'(stage_status_ff) == CHG_DONE)
                                : terminated_ff;

      count_adv   = count_ff;
      latched_adv = latched_ff;
      if (armed_ff && !latched_ff) begin
         if (count_ff != {TIMER_BITS{1'b1}}) begin
            count_adv = count_ff + TIMER_BITS'(1);
         end
         latched_adv = (CMP_W'(count_adv) >= CMP_W'(full_timeout_ff));
      end

      powered = stage_pc_ff || stage_pp_ff;
      if (!powered) begin
         state_now = CS_NOT_CHARGING;
      end else if (latched_adv || term_status) begin
         state_now = CS_FULL;
      end else if (stage_level_ff >= LEVEL_W'(near_full_ff)) begin
         state_now = CS_NEARLY_DONE;
      end else begin
         state_now = CS_CHARGING;
      end
      terminated_in = powered && term_status;
      last_state_in = state_now;

      run = stage_pp_ff && (!stage_healthy_ff ||
            (stage_temp_ff > min_temp_ff && stage_temp_ff < max_temp_ff));
      armed_in   = armed_ff;
      count_in   = count_adv;
      latched_in = latched_adv;
      if (run && !armed_ff) begin
         armed_in   = 1'b1;
         count_in   = '0;
         latched_in = 1'b0;
      end else if (!run && armed_ff) begin
         armed_in   = 1'b0;
         latched_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terminated_ff <= 1'b0;
         last_state_ff <= CS_UNKNOWN;
         armed_ff      <= 1'b0;
         count_ff      <= '0;
         latched_ff    <= 1'b0;
      end else if (advance) begin
         terminated_ff <= terminated_in;
         last_state_ff <= last_state_in;
         armed_ff      <= armed_in;
         count_ff      <= count_in;
         latched_ff    <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff   <= state_now;
         rsp_changed_ff <= (state_now != last_state_ff);
         rsp_display_ff <= display_of(stage_level_ff);
         rsp_term_ff    <= terminated_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.chg_state         = rsp_state_ff;
   assign rsp_chan.state_changed     = rsp_changed_ff;
   assign rsp_chan.display_level     = rsp_display_ff;
   assign rsp_chan.charge_terminated = rsp_term_ff;

   // latch is only ever set by a running timer and cleared when it stops
   a_latch_needs_armed: assert property (@(posedge clock) disable iff (reset)
      latched_ff |-> armed_ff)
      else $error("timeout latched while timer disarmed");

   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> stage_valid_ff)
      else $error("accepted request lost before input register");

   a_term_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_term_ff) |-> (rsp_state_ff == CS_FULL))
      else $error("terminated flag reported without full state");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_level_ff)))
      else $error("input register changed while stalled");

endmodule
